// File: src/xzbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xzbh_pkg: shared types and helpers of the block header parser
// Phase codes, status codes, result record type and the bytewise CRC-32.
// ----------------------------------------------------------------------------
package xzbh_pkg;

    localparam int PropCaptureBytesDefault = 8;
    localparam int QueueDepth = 2;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_INDEX     = 4'd1,
        ST_RESERVED  = 4'd2,
        ST_BAD_CSIZE = 4'd3,
        ST_BAD_USIZE = 4'd4,
        ST_BAD_FID   = 4'd5,
        ST_BAD_PLEN  = 4'd6,
        ST_PROPS_OVR = 4'd7,
        ST_PADDING   = 4'd8,
        ST_CRC       = 4'd9
    } status_t;

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_FLAGS  = 9'b000000010,
        PH_CSIZE  = 9'b000000100,
        PH_USIZE  = 9'b000001000,
        PH_FID    = 9'b000010000,
        PH_FPLEN  = 9'b000100000,
        PH_FPROPS = 9'b001000000,
        PH_PAD    = 9'b010000000,
        PH_CRC    = 9'b100000000
    } phase_t;

    localparam logic [7:0] FlagCountMask    = 8'h03;
    localparam logic [7:0] FlagReservedMask = 8'h3C;
    localparam logic [7:0] FlagCsize        = 8'h40;
    localparam logic [7:0] FlagUsize        = 8'h80;
    localparam logic [3:0] VarintMaxBytes   = 4'd9;

    typedef struct packed {
        logic        kind;
        logic [3:0]  status;
        logic [1:0]  filter_index;
        logic [62:0] filter_id;
        logic [9:0]  property_length;
        logic [63:0] property_word;
        logic        has_compressed_size;
        logic [62:0] compressed_size;
        logic        has_uncompressed_size;
        logic [62:0] uncompressed_size;
        logic [2:0]  filter_count;
        logic [9:0]  header_length;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: src/xzbh_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xzbh_parser: front end of the block header parser
// Takes one byte a cycle while in_fire is set, tracks the parse phase and builds result records.
// ----------------------------------------------------------------------------
module xzbh_parser
    import xzbh_pkg::*;
#(
    parameter int PROPERTY_CAPTURE_BYTES = PropCaptureBytesDefault
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic [7:0]    data_byte,
    input  logic          first_byte,
    output logic          res_valid,
    output result_t       res
);

    phase_t      phase_reg, phase_next;
    logic [9:0]  pos_reg, pos_next;
    logic [9:0]  hend_reg, hend_next;
    logic [7:0]  flags_reg, flags_next;
    logic [62:0] acc_reg, acc_next;
    logic [3:0]  vbytes_reg, vbytes_next;
    logic [1:0]  cur_reg, cur_next;
    logic [62:0] fid_reg, fid_next;
    logic [9:0]  prem_reg, prem_next;
    logic [9:0]  plen_reg, plen_next;
    logic [63:0] pcap_reg, pcap_next;
    logic [62:0] csz_reg, csz_next;
    logic [62:0] usz_reg, usz_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] crcr_reg, crcr_next;
    logic [1:0]  crcn_reg, crcn_next;

    // Phase after any header-end redirect (the record is built from out_phase).
    phase_t      eff;
    logic        emit, emit_kind;
    status_t     emit_status;
    logic [62:0] vnew;
    logic [9:0]  pk;
    logic [10:0] left;
    phase_t      out_phase;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        hend_next   = hend_reg;
        flags_next  = flags_reg;
        acc_next    = acc_reg;
        vbytes_next = vbytes_reg;
        cur_next    = cur_reg;
        fid_next    = fid_reg;
        prem_next   = prem_reg;
        plen_next   = plen_reg;
        pcap_next   = pcap_reg;
        csz_next    = csz_reg;
        usz_next    = usz_reg;
        crc_next    = crc_reg;
        crcr_next   = crcr_reg;
        crcn_next   = crcn_reg;
        emit        = 1'b0;
        emit_kind   = 1'b1;
        emit_status = ST_OK;
        eff         = phase_reg;
        out_phase   = phase_reg;
        vnew        = acc_reg | (63'(data_byte[6:0]) << (7 * vbytes_reg));
        pk          = plen_reg - prem_reg;
        left        = {1'b0, hend_reg} - ({1'b0, pos_reg} + 11'd1);
        if (in_fire)
        begin
            if (first_byte)
            begin
                hend_next   = {data_byte, 2'b00};
                crc_next    = crc_byte(32'hFFFFFFFF, data_byte);
                pos_next    = 10'd1;
                flags_next  = '0;
                acc_next    = '0;
                vbytes_next = '0;
                cur_next    = '0;
                fid_next    = '0;
                prem_next   = '0;
                plen_next   = '0;
                pcap_next   = '0;
                csz_next    = '0;
                usz_next    = '0;
                crcr_next   = '0;
                crcn_next   = '0;
                out_phase   = PH_IDLE;
                if (data_byte == 8'd0)
                begin
                    emit        = 1'b1;
                    emit_status = ST_INDEX;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_FLAGS;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                pos_next = pos_reg + 10'd1;
                if (pos_reg >= hend_reg)
                begin
                    case (phase_reg)
                        PH_CSIZE: begin emit = 1'b1; emit_status = ST_BAD_CSIZE; end
                        PH_USIZE: begin emit = 1'b1; emit_status = ST_BAD_USIZE; end
                        PH_FID:   begin emit = 1'b1; emit_status = ST_BAD_FID; end
                        PH_FPLEN: begin emit = 1'b1; emit_status = ST_BAD_PLEN; end
                        default:  eff = PH_CRC;
                    endcase
                end
                else
                begin
                    crc_next = crc_byte(crc_reg, data_byte);
                end
                out_phase = eff;
                if (!emit)
                begin
                    phase_next = eff;
                    case (eff)
                        PH_FLAGS:
                        begin
                            flags_next  = data_byte;
                            acc_next    = '0;
                            vbytes_next = '0;
                            if ((data_byte & FlagReservedMask) != 8'd0)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_RESERVED;
                                out_phase   = PH_FID;
                            end
                            else if ((data_byte & FlagCsize) != 8'd0)
                                phase_next = PH_CSIZE;
                            else if ((data_byte & FlagUsize) != 8'd0)
                                phase_next = PH_USIZE;
                            else
                                phase_next = PH_FID;
                        end
                        PH_CSIZE, PH_USIZE, PH_FID, PH_FPLEN:
                        begin
                            acc_next    = vnew;
                            vbytes_next = vbytes_reg + 4'd1;
                            if (data_byte[7])
                            begin
                                if (vbytes_reg + 4'd1 >= VarintMaxBytes)
                                begin
                                    emit = 1'b1;
                                    case (eff)
                                        PH_CSIZE: emit_status = ST_BAD_CSIZE;
                                        PH_USIZE: emit_status = ST_BAD_USIZE;
                                        PH_FID:   emit_status = ST_BAD_FID;
                                        default:  emit_status = ST_BAD_PLEN;
                                    endcase
                                end
                            end
                            else
                            begin
                                acc_next    = '0;
                                vbytes_next = '0;
                                case (eff)
                                    PH_CSIZE:
                                    begin
                                        csz_next   = vnew;
                                        phase_next = flags_reg[7] ? PH_USIZE : PH_FID;
                                    end
                                    PH_USIZE:
                                    begin
                                        usz_next   = vnew;
                                        phase_next = PH_FID;
                                    end
                                    PH_FID:
                                    begin
                                        fid_next   = vnew;
                                        phase_next = PH_FPLEN;
                                    end
                                    default:
                                    begin
                                        if (vnew > 63'(left))
                                        begin
                                            emit        = 1'b1;
                                            emit_status = ST_PROPS_OVR;
                                        end
                                        else
                                        begin
                                            plen_next = vnew[9:0];
                                            prem_next = vnew[9:0];
                                            pcap_next = '0;
                                            if (vnew == 63'd0)
                                            begin
                                                emit      = 1'b1;
                                                emit_kind = 1'b0;
                                            end
                                            else
                                                phase_next = PH_FPROPS;
                                        end
                                    end
                                endcase
                            end
                        end
                        PH_FPROPS:
                        begin
                            if (pk < 10'(PROPERTY_CAPTURE_BYTES))
                                pcap_next = pcap_reg | (64'(data_byte) << {pk[2:0], 3'b000});
                            prem_next = prem_reg - 10'd1;
                            if (prem_reg == 10'd1)
                            begin
                                emit      = 1'b1;
                                emit_kind = 1'b0;
                            end
                        end
                        PH_PAD:
                        begin
                            if (data_byte != 8'd0)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_PADDING;
                            end
                        end
                        PH_CRC:
                        begin
                            crcr_next = crcr_reg | (32'(data_byte) << {crcn_reg, 3'b000});
                            if (crcn_reg == 2'd3)
                            begin
                                crcn_next   = '0;
                                emit        = 1'b1;
                                emit_status = ((crc_reg ^ 32'hFFFFFFFF) == crcr_next)
                                              ? ST_OK : ST_CRC;
                            end
                            else
                                crcn_next = crcn_reg + 2'd1;
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
                if (emit)
                begin
                    if (emit_kind)
                        phase_next = PH_IDLE;
                    else
                    begin
                        acc_next    = '0;
                        vbytes_next = '0;
                        if (cur_reg >= flags_reg[1:0])
                            phase_next = PH_PAD;
                        else
                        begin
                            cur_next   = cur_reg + 2'd1;
                            phase_next = PH_FID;
                        end
                    end
                end
            end
        end
    end

    // Record fields use the size holders after this byte's update.
    always_comb
    begin
        res_valid = emit;
        res.kind   = emit_kind;
        res.status = emit_kind ? emit_status : ST_OK;
        res.filter_index    = emit_kind ? 2'd0 : cur_reg;
        res.filter_id       = emit_kind ? 63'd0 : fid_reg;
        res.property_length = emit_kind ? 10'd0 : plen_next;
        res.property_word   = emit_kind ? 64'd0 : pcap_next;
        res.has_compressed_size   = (out_phase != PH_FLAGS) && flags_next[6];
        res.compressed_size       = csz_next;
        res.has_uncompressed_size = (out_phase != PH_FLAGS) && flags_next[7];
        res.uncompressed_size     = usz_next;
        res.filter_count = (out_phase == PH_IDLE || out_phase == PH_FLAGS) ? 3'd0
                           : ({1'b0, flags_next[1:0]} + 3'd1);
        res.header_length = hend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            hend_reg   <= '0;
            flags_reg  <= '0;
            acc_reg    <= '0;
            vbytes_reg <= '0;
            cur_reg    <= '0;
            fid_reg    <= '0;
            prem_reg   <= '0;
            plen_reg   <= '0;
            pcap_reg   <= '0;
            csz_reg    <= '0;
            usz_reg    <= '0;
            crc_reg    <= 32'hFFFFFFFF;
            crcr_reg   <= '0;
            crcn_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            hend_reg   <= hend_next;
            flags_reg  <= flags_next;
            acc_reg    <= acc_next;
            vbytes_reg <= vbytes_next;
            cur_reg    <= cur_next;
            fid_reg    <= fid_next;
            prem_reg   <= prem_next;
            plen_reg   <= plen_next;
            pcap_reg   <= pcap_next;
            csz_reg    <= csz_next;
            usz_reg    <= usz_next;
            crc_reg    <= crc_next;
            crcr_reg   <= crcr_next;
            crcn_reg   <= crcn_next;
        end
    end

endmodule

// File: src/xzbh_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xzbh_out_queue: result queue and output stage
// A small first-in first-out store between the parser and the result stream.
// ----------------------------------------------------------------------------
module xzbh_out_queue
    import xzbh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    has_room,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data
);

    localparam int AW = $clog2(QueueDepth);

    result_t       mem_reg [QueueDepth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          rd_en;

    assign rd_en    = rd_valid && rd_ready;
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    // Room for one more even if nothing leaves this cycle.
    assign has_room = cnt_reg < (AW+1)'(QueueDepth);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

// File: src/xz_block_header_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xz_block_header_parser_core: streaming parser for xz block headers
// Parses the header bytes, emits one record per filter and a final result.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata = data_byte, tuser = first_byte
// m_axis    out        tdata = result record, tuser = kind
//
// One byte is taken each cycle; the parser, its varint decoder and the
// bytewise CRC-32 update all finish within that cycle. A result enters a
// two-entry queue and leaves from there, so the input stalls whenever the
// queue is full, since any accepted byte could add a result. Reset (rst_n low,
// asynchronous) returns the parser to idle and empties the queue.
module xz_block_header_parser_core
    import xzbh_pkg::*;
#(
    parameter int PROPERTY_CAPTURE_BYTES = PropCaptureBytesDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte[7:0]
    input  logic         s_axis_tuser,   // first_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[3:0], filter_index[5:4], filter_id[68:6], property_length[78:69],
    // property_word[142:79], has_compressed_size[143], compressed_size[206:144],
    // has_uncompressed_size[207], uncompressed_size[270:208],
    // filter_count[273:271], header_length[283:274], zero fill to 287
    output logic [287:0] m_axis_tdata,
    output logic         m_axis_tuser    // kind
);

    logic    in_fire;
    logic    res_valid;
    logic    q_room;
    result_t res, q_data;

    // Every accepted byte can produce a result, so hold input when no room.
    assign s_axis_tready = q_room;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    xzbh_parser #(
        .PROPERTY_CAPTURE_BYTES(PROPERTY_CAPTURE_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (s_axis_tdata),
        .first_byte(s_axis_tuser),
        .res_valid (res_valid),
        .res       (res)
    );

    xzbh_out_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .has_room(q_room),
        .rd_valid(m_axis_tvalid),
        .rd_ready(m_axis_tready),
        .rd_data (q_data)
    );

    assign m_axis_tuser = q_data.kind;
    assign m_axis_tdata = {4'd0, q_data.header_length, q_data.filter_count,
                           q_data.uncompressed_size, q_data.has_uncompressed_size,
                           q_data.compressed_size, q_data.has_compressed_size,
                           q_data.property_word, q_data.property_length,
                           q_data.filter_id, q_data.filter_index, q_data.status};

`ifndef ASSERT_OFF
    // A result is only produced by an accepted byte.
    a_res_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_fire) else $error("result without input byte");

    // Filter records always carry ok status.
    a_filter_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[3:0] == 4'd0))
        else $error("filter record with error status");

    // Index indicator result follows a zero size byte marked as first.
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser && s_axis_tdata == 8'd0) |-> res_valid)
        else $error("missing index indicator result");
`endif

endmodule
